/* hw/rtl/ccsd_pkg.sv */
// ----------------------------------------------------------------------------
// ccsd_pkg
// Shared types and constants of the character canvas shape drawer.
// ----------------------------------------------------------------------------
package ccsd_pkg;

   localparam int COORD_W  = 7;
   localparam int CHAR_W   = 8;
   localparam int OP_W     = 3;
   localparam int CFG_W    = 7;
   localparam int CSR_IDX_W = 1;
   localparam int RSQ_W    = 2 * COORD_W;
   localparam int OUTER_W  = 2 * COORD_W + 1;

   localparam logic [CHAR_W-1:0] CH_DASH  = 8'd45;
   localparam logic [CHAR_W-1:0] CH_BAR   = 8'd124;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CH_NONE  = 8'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_SET   = 3'd0,
      OP_RECT  = 3'd1,
      OP_FILL  = 3'd2,
      OP_RING  = 3'd3,
      OP_DISC  = 3'd4,
      OP_CLEAR = 3'd5,
      OP_READ  = 3'd6
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_WRITE,
      KIND_SHAPE,
      KIND_CLEAR,
      KIND_READ_MEM,
      KIND_READ_CONST
   } cmd_kind_type;

   // fill_char carries the border or zero code for a constant read
   typedef struct packed {
      cmd_kind_type                kind;
      opcode_type                  op;
      logic [COORD_W-1:0]          row_a;
      logic [COORD_W-1:0]          col_a;
      logic [COORD_W-1:0]          row_b;
      logic [COORD_W-1:0]          col_b;
      logic [RSQ_W-1:0]            r_sq;
      logic [OUTER_W-1:0]          outer_sq;
      logic [CHAR_W-1:0]           fill_char;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SWEEP,
      ST_DRAIN,
      ST_READ
   } back_state_type;

endpackage

/* hw/rtl/ccsd_ram.sv */
// ----------------------------------------------------------------------------
// ccsd_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ccsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/ccsd_queue.sv */
// ----------------------------------------------------------------------------
// ccsd_queue
// Two-entry command queue between the classifier and the drawing engine.
// ----------------------------------------------------------------------------
module ccsd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ccsd_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output ccsd_pkg::cmd_type head_cmd
);

   ccsd_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/ccsd_front.sv */
// ----------------------------------------------------------------------------
// ccsd_front
// Command classifier: decides the work of each beat and feeds the queue.
// ----------------------------------------------------------------------------
module ccsd_front #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ccsd_pkg::OP_W-1:0]             req_opcode,
   input  logic [ccsd_pkg::COORD_W-1:0]          req_row_a,
   input  logic [ccsd_pkg::COORD_W-1:0]          req_col_a,
   input  logic [ccsd_pkg::COORD_W-1:0]          req_row_b,
   input  logic [ccsd_pkg::COORD_W-1:0]          req_col_b,
   input  logic [ccsd_pkg::COORD_W-1:0]          req_radius,
   input  logic [ccsd_pkg::CHAR_W-1:0]           req_fill_char,
   input  logic [$clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 2)-1:0]
                                                 width,
   input  logic [$clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 2)-1:0]
                                                 height,
   input  ccsd_pkg::back_status_type             back_status,
   input  logic                                  q_full,
   output logic                                  q_push,
   output ccsd_pkg::cmd_type                     q_cmd
);

   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int SW      = $clog2(MAX_DIM + 2);
   localparam int CW      = (SW > ccsd_pkg::COORD_W) ? SW : ccsd_pkg::COORD_W;
   localparam int XW      = CW + 1;

   ccsd_pkg::opcode_type          op;
   logic [XW-1:0]                 ra_x;
   logic [XW-1:0]                 ca_x;
   logic [XW-1:0]                 h_x;
   logic [XW-1:0]                 w_x;
   logic                          interior;
   logic                          keep;
   logic [ccsd_pkg::COORD_W:0]    rp1;

   assign req_ready = !q_full && !back_status.init_busy;
   assign q_push    = req_valid && req_ready && keep;

   always_comb begin
      op       = ccsd_pkg::opcode_type'(req_opcode);
      ra_x     = XW'(req_row_a);
      ca_x     = XW'(req_col_a);
      h_x      = XW'(height);
      w_x      = XW'(width);
      interior = (ra_x != '0) && (ra_x <= h_x) && (ca_x != '0) && (ca_x <= w_x);
      rp1      = {1'b0, req_radius} + 1'b1;

      q_cmd.kind      = ccsd_pkg::KIND_SHAPE;
      q_cmd.op        = op;
      q_cmd.row_a     = req_row_a;
      q_cmd.col_a     = req_col_a;
      q_cmd.row_b     = req_row_b;
      q_cmd.col_b     = req_col_b;
      q_cmd.r_sq      = ccsd_pkg::RSQ_W'(req_radius) * ccsd_pkg::RSQ_W'(req_radius);
      q_cmd.outer_sq  = ccsd_pkg::OUTER_W'(rp1) * ccsd_pkg::OUTER_W'(rp1);
      q_cmd.fill_char = req_fill_char;
      keep            = 1'b0;

      unique case (op)
         ccsd_pkg::OP_SET: begin
            q_cmd.kind = ccsd_pkg::KIND_WRITE;
            keep       = interior;
         end
         ccsd_pkg::OP_RECT, ccsd_pkg::OP_FILL, ccsd_pkg::OP_RING, ccsd_pkg::OP_DISC: begin
            q_cmd.kind = ccsd_pkg::KIND_SHAPE;
            keep       = 1'b1;
         end
         ccsd_pkg::OP_CLEAR: begin
            q_cmd.kind = ccsd_pkg::KIND_CLEAR;
            keep       = 1'b1;
         end
         ccsd_pkg::OP_READ: begin
            keep = 1'b1;
            // frame and off-canvas reads never touch the store
            priority if ((ra_x > h_x + 1'b1) || (ca_x > w_x + 1'b1)) begin
               q_cmd.kind      = ccsd_pkg::KIND_READ_CONST;
               q_cmd.fill_char = ccsd_pkg::CH_NONE;
            end else if ((ra_x == '0) || (ra_x == h_x + 1'b1)) begin
               q_cmd.kind      = ccsd_pkg::KIND_READ_CONST;
               q_cmd.fill_char = ccsd_pkg::CH_DASH;
            end else if ((ca_x == '0) || (ca_x == w_x + 1'b1)) begin
               q_cmd.kind      = ccsd_pkg::KIND_READ_CONST;
               q_cmd.fill_char = ccsd_pkg::CH_BAR;
            end else begin
               q_cmd.kind = ccsd_pkg::KIND_READ_MEM;
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule

/* hw/rtl/ccsd_back.sv */
// ----------------------------------------------------------------------------
// ccsd_back
// Drawing engine: clears, sweeps the canvas for shapes, writes and reads cells.
// ----------------------------------------------------------------------------
module ccsd_back #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [$clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 2)-1:0]
                                                 width,
   input  logic [$clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 2)-1:0]
                                                 height,
   input  logic                                  q_valid,
   input  ccsd_pkg::cmd_type                     q_cmd,
   output logic                                  q_pop,
   output ccsd_pkg::back_status_type             back_status,
   output logic                                  ram_we,
   output logic [((MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1)-1:0]
                                                 ram_waddr,
   output logic [ccsd_pkg::CHAR_W-1:0]           ram_wdata,
   output logic                                  ram_re,
   output logic [((MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1)-1:0]
                                                 ram_raddr,
   input  logic [ccsd_pkg::CHAR_W-1:0]           ram_rdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ccsd_pkg::CHAR_W-1:0]           rsp_cell_char
);

   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int SW      = $clog2(MAX_DIM + 2);
   localparam int CW      = (SW > ccsd_pkg::COORD_W) ? SW : ccsd_pkg::COORD_W;
   localparam int PW      = 2 * CW;
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   ccsd_pkg::back_state_type state_ff;
   ccsd_pkg::back_state_type state_in;
   ccsd_pkg::cmd_type        cur_ff;
   ccsd_pkg::cmd_type        cur_in;

   logic [AW-1:0]            addr_ff;
   logic [AW-1:0]            addr_in;
   logic [AW-1:0]            rowbase_ff;
   logic [AW-1:0]            rowbase_in;
   logic [SW-1:0]            row_ff;
   logic [SW-1:0]            row_in;
   logic [SW-1:0]            col_ff;
   logic [SW-1:0]            col_in;

   logic                     p_valid_ff;
   logic                     p_valid_in;
   logic [AW-1:0]            p_addr_ff;
   logic [AW-1:0]            p_addr_in;
   logic [PW-1:0]            p_dr2_ff;
   logic [PW-1:0]            p_dr2_in;
   logic [PW-1:0]            p_dc2_ff;
   logic [PW-1:0]            p_dc2_in;
   logic                     p_rect_ff;
   logic                     p_rect_in;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [ccsd_pkg::CHAR_W-1:0] rsp_char_ff;
   logic [ccsd_pkg::CHAR_W-1:0] rsp_char_in;

   logic                     out_free;
   logic                     clr_last;
   logic                     col_last;
   logic                     row_last;
   logic                     start;
   logic                     clr_we;
   logic                     issue;
   logic                     set_we;
   logic                     mem_re;
   logic                     load_const;
   logic                     load_mem;
   logic                     pipe_we;
   logic                     hit;

   logic [CW-1:0]            row_x;
   logic [CW-1:0]            col_x;
   logic [CW-1:0]            ra_x;
   logic [CW-1:0]            ca_x;
   logic [CW-1:0]            rb_x;
   logic [CW-1:0]            cb_x;
   logic [CW-1:0]            dr;
   logic [CW-1:0]            dc;
   logic                     outline;
   logic                     filled;
   logic [PW:0]              d2;

   logic [CW-1:0]            q_row_m1;
   logic [CW-1:0]            q_col_m1;
   logic [CW+AW-1:0]         q_prod;
   logic [AW-1:0]            q_addr;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign clr_last = (addr_ff == AW'(DEPTH - 1));
   assign col_last = (col_ff == width);
   assign row_last = (row_ff == height);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ccsd_pkg::ST_INIT, ccsd_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = ccsd_pkg::ST_IDLE;
            end
         end
         ccsd_pkg::ST_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  ccsd_pkg::KIND_CLEAR:    state_in = ccsd_pkg::ST_CLEAR;
                  ccsd_pkg::KIND_SHAPE:    state_in = ccsd_pkg::ST_SWEEP;
                  ccsd_pkg::KIND_READ_MEM: state_in = ccsd_pkg::ST_READ;
                  default:                 state_in = ccsd_pkg::ST_IDLE;
               endcase
            end
         end
         ccsd_pkg::ST_SWEEP: begin
            if (col_last && row_last) begin
               state_in = ccsd_pkg::ST_DRAIN;
            end
         end
         ccsd_pkg::ST_DRAIN: begin
            state_in = ccsd_pkg::ST_IDLE;
         end
         ccsd_pkg::ST_READ: begin
            if (out_free) begin
               state_in = ccsd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ccsd_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      clr_we     = 1'b0;
      issue      = 1'b0;
      set_we     = 1'b0;
      mem_re     = 1'b0;
      load_const = 1'b0;
      load_mem   = 1'b0;
      q_pop      = 1'b0;
      start      = 1'b0;
      back_status.init_busy = (state_ff == ccsd_pkg::ST_INIT);
      unique case (state_ff)
         ccsd_pkg::ST_INIT, ccsd_pkg::ST_CLEAR: begin
            clr_we = 1'b1;
         end
         ccsd_pkg::ST_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  ccsd_pkg::KIND_WRITE: begin
                     set_we = 1'b1;
                     q_pop  = 1'b1;
                  end
                  ccsd_pkg::KIND_READ_MEM: begin
                     mem_re = 1'b1;
                     q_pop  = 1'b1;
                  end
                  ccsd_pkg::KIND_READ_CONST: begin
                     load_const = out_free;
                     q_pop      = out_free;
                  end
                  default: begin
                     start = 1'b1;
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ccsd_pkg::ST_SWEEP: begin
            issue = 1'b1;
         end
         ccsd_pkg::ST_READ: begin
            load_mem = out_free;
         end
         default: begin
            clr_we = 1'b0;
         end
      endcase
   end

   // cell address of a single-cell write or read
   always_comb begin
      q_row_m1 = CW'(q_cmd.row_a) - 1'b1;
      q_col_m1 = CW'(q_cmd.col_a) - 1'b1;
      q_prod   = (CW + AW)'(q_row_m1) * (CW + AW)'(MAX_WIDTH);
      q_addr   = q_prod[AW-1:0] + AW'(q_col_m1);
   end

   // sweep and clear counters
   always_comb begin
      cur_in     = start ? q_cmd : cur_ff;
      addr_in    = addr_ff;
      rowbase_in = rowbase_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      priority if (start) begin
         addr_in    = '0;
         rowbase_in = '0;
         row_in     = SW'(1);
         col_in     = SW'(1);
      end else if (clr_we) begin
         addr_in = addr_ff + 1'b1;
      end else if (issue) begin
         if (col_last) begin
            addr_in    = rowbase_ff + AW'(MAX_WIDTH);
            rowbase_in = rowbase_ff + AW'(MAX_WIDTH);
            row_in     = row_ff + 1'b1;
            col_in     = SW'(1);
         end else begin
            addr_in = addr_ff + 1'b1;
            col_in  = col_ff + 1'b1;
         end
      end
   end

   // issue stage: distances and rectangle tests
   always_comb begin
      row_x   = CW'(row_ff);
      col_x   = CW'(col_ff);
      ra_x    = CW'(cur_ff.row_a);
      ca_x    = CW'(cur_ff.col_a);
      rb_x    = CW'(cur_ff.row_b);
      cb_x    = CW'(cur_ff.col_b);
      dr      = (row_x >= ra_x) ? row_x - ra_x : ra_x - row_x;
      dc      = (col_x >= ca_x) ? col_x - ca_x : ca_x - col_x;
      outline = ((col_x >= ca_x) && (col_x <= cb_x) && ((row_x == ra_x) || (row_x == rb_x)))
             || ((row_x >= ra_x) && (row_x <= rb_x) && ((col_x == ca_x) || (col_x == cb_x)));
      filled  = (row_x >= ra_x) && (row_x <= rb_x) && (col_x >= ca_x) && (col_x <= cb_x);

      p_valid_in = issue;
      p_addr_in  = addr_ff;
      p_dr2_in   = PW'(dr) * PW'(dr);
      p_dc2_in   = PW'(dc) * PW'(dc);
      p_rect_in  = (cur_ff.op == ccsd_pkg::OP_RECT) ? outline : filled;
   end

   // write stage: ring and disc tests on the registered squares, rectangle result as registered
   always_comb begin
      d2 = {1'b0, p_dr2_ff} + {1'b0, p_dc2_ff};
      unique case (cur_ff.op)
         ccsd_pkg::OP_RECT, ccsd_pkg::OP_FILL: hit = p_rect_ff;
         ccsd_pkg::OP_RING: hit = (d2 >= (PW + 1)'(cur_ff.r_sq))
                               && (d2 < (PW + 1)'(cur_ff.outer_sq));
         ccsd_pkg::OP_DISC: hit = (d2 < (PW + 1)'(cur_ff.outer_sq));
         default:           hit = 1'b0;
      endcase
      pipe_we = p_valid_ff && hit;
   end

   // store write and read ports
   always_comb begin
      ram_we = pipe_we || set_we || clr_we;
      priority if (pipe_we) begin
         ram_waddr = p_addr_ff;
         ram_wdata = cur_ff.fill_char;
      end else if (set_we) begin
         ram_waddr = q_addr;
         ram_wdata = q_cmd.fill_char;
      end else begin
         ram_waddr = addr_ff;
         ram_wdata = ccsd_pkg::CH_SPACE;
      end
      ram_re    = mem_re;
      ram_raddr = q_addr;
   end

   // result register
   always_comb begin
      rsp_char_in  = rsp_char_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      priority if (load_const) begin
         rsp_char_in  = q_cmd.fill_char;
         rsp_valid_in = 1'b1;
      end else if (load_mem) begin
         rsp_char_in  = ram_rdata;
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_char = rsp_char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccsd_pkg::ST_INIT;
         addr_ff      <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rowbase_ff  <= rowbase_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      p_addr_ff   <= p_addr_in;
      p_dr2_ff    <= p_dr2_in;
      p_dc2_ff    <= p_dc2_in;
      p_rect_ff   <= p_rect_in;
      rsp_char_ff <= rsp_char_in;
   end

endmodule

/* hw/rtl/char_canvas_shape_drawer_unit.sv */
// ----------------------------------------------------------------------------
// char_canvas_shape_drawer_unit
// Character cell canvas: cell writes, rectangles, rings, discs, clear, reads.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  opcode, corners, radius, fill_char
//   rsp_     out        rsp_valid/rsp_ready  cell_char (reads only)
//   csr_     in         csr_we               csr_index, csr_wdata
//
// a cell write or a read is taken from the queue by the engine, a read waiting
// while an earlier result is held with rsp_ready low; a shape sweeps every
// interior cell once; a clear walks the whole store; cell writes, shapes and
// clears share the single store write port. after reset the store is wiped to
// spaces with req_ready low. a two-entry queue keeps accepting beats until it
// is full while the engine works or while a read result waits on rsp_ready.
module char_canvas_shape_drawer_unit #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ccsd_pkg::OP_W-1:0]        req_opcode,
   input  logic [ccsd_pkg::COORD_W-1:0]     req_row_a,
   input  logic [ccsd_pkg::COORD_W-1:0]     req_col_a,
   input  logic [ccsd_pkg::COORD_W-1:0]     req_row_b,
   input  logic [ccsd_pkg::COORD_W-1:0]     req_col_b,
   input  logic [ccsd_pkg::COORD_W-1:0]     req_radius,
   input  logic [ccsd_pkg::CHAR_W-1:0]      req_fill_char,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ccsd_pkg::CHAR_W-1:0]      rsp_cell_char,
   input  logic                             csr_we,
   input  logic [ccsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ccsd_pkg::CFG_W-1:0]       csr_wdata
);

   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int SW      = $clog2(MAX_DIM + 2);
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [SW-1:0]               width_ff;
   logic [SW-1:0]               width_in;
   logic [SW-1:0]               height_ff;
   logic [SW-1:0]               height_in;

   logic                        q_full;
   logic                        q_push;
   ccsd_pkg::cmd_type           q_push_cmd;
   logic                        q_pop;
   logic                        q_valid;
   ccsd_pkg::cmd_type           q_head;
   ccsd_pkg::back_status_type   back_status;

   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [ccsd_pkg::CHAR_W-1:0] ram_wdata;
   logic                        ram_re;
   logic [AW-1:0]               ram_raddr;
   logic [ccsd_pkg::CHAR_W-1:0] ram_rdata;

   function automatic logic [SW-1:0] clamp_size(input logic [ccsd_pkg::CFG_W-1:0] v,
                                                input int maxv);
      logic [SW-1:0] res;
      if (v == '0) begin
         res = SW'(1);
      end else if (int'(v) > maxv) begin
         res = SW'(maxv);
      end else begin
         res = SW'(v);
      end
      return res;
   endfunction

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         if (csr_index == ccsd_pkg::CSR_CANVAS_WIDTH) begin
            width_in = clamp_size(csr_wdata, MAX_WIDTH);
         end else if (csr_index == ccsd_pkg::CSR_CANVAS_HEIGHT) begin
            height_in = clamp_size(csr_wdata, MAX_HEIGHT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SW'(MAX_WIDTH);
         height_ff <= SW'(MAX_HEIGHT);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   ccsd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_row_a     (req_row_a),
      .req_col_a     (req_col_a),
      .req_row_b     (req_row_b),
      .req_col_b     (req_col_b),
      .req_radius    (req_radius),
      .req_fill_char (req_fill_char),
      .width         (width_ff),
      .height        (height_ff),
      .back_status   (back_status),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_push_cmd)
   );

   ccsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (q_head)
   );

   ccsd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .width         (width_ff),
      .height        (height_ff),
      .q_valid       (q_valid),
      .q_cmd         (q_head),
      .q_pop         (q_pop),
      .back_status   (back_status),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_char (rsp_cell_char)
   );

   ccsd_ram #(
      .WIDTH (ccsd_pkg::CHAR_W),
      .DEPTH (DEPTH)
   ) u_cell_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

/* hw/rtl/ccsd_checker.sv */
// ----------------------------------------------------------------------------
// ccsd_checker
// Port level checks of the canvas drawer, bound to the top level.
// ----------------------------------------------------------------------------
module ccsd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [ccsd_pkg::OP_W-1:0]    req_opcode,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ccsd_pkg::CHAR_W-1:0]  rsp_cell_char
);

   logic [3:0] pend_ff;
   logic [3:0] pend_in;
   logic       read_beat;
   logic       rsp_beat;

   assign read_beat = req_valid && req_ready && (req_opcode == ccsd_pkg::OP_READ);
   assign rsp_beat  = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff + 4'(read_beat) - 4'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // store wipe after reset holds off requests
   a_init_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during store wipe");

   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_char))
      else $error("stalled result changed");

   // every result beat answers an earlier read beat
   a_rsp_has_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("result without pending read");

endmodule

bind char_canvas_shape_drawer_unit ccsd_checker u_ccsd_checker (.*);
